// ----- rtl/xcs_pkg.sv -----
// ----------------------------------------------------------------------------
// xcs_pkg
// Shared types, character codes and result builders for the XMODEM
// checksum sender.
// ----------------------------------------------------------------------------
package xcs_pkg;

  localparam int BLOCK_BYTES_DEF = 128;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [3:0] RETRIES_RST    = 4'd3;
  localparam logic [7:0] START_CHAR_RST = 8'h33;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_ANSWER = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_EOF    = 3'd4;

  localparam logic [2:0] EV_SEND        = 3'd0;
  localparam logic [2:0] EV_REJECT      = 3'd1;
  localparam logic [2:0] EV_DONE        = 3'd2;
  localparam logic [2:0] EV_NAK_ABORT   = 3'd3;
  localparam logic [2:0] EV_RETRY_ABORT = 3'd4;
  localparam logic [2:0] EV_START_FAIL  = 3'd5;

  localparam logic CFG_RETRIES    = 1'b0;
  localparam logic CFG_START_CHAR = 1'b1;

  typedef struct packed {
    logic [3:0] answer_retries;
    logic [7:0] start_char;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [2:0] event_res;
    logic       is_send;
  } res_t;

  // Up to four results caused by one transaction
  typedef struct packed {
    logic [2:0]      count;
    res_t [3:0]      ent;
  } pkt_t;

  function automatic res_t mk_send(input logic [7:0] b);
    res_t r;
    r.tx_byte   = b;
    r.event_res = EV_SEND;
    r.is_send   = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic [2:0] ev,
                                  input logic snd);
    res_t r;
    r.tx_byte   = b;
    r.event_res = ev;
    r.is_send   = snd;
    return r;
  endfunction

endpackage

// ----- rtl/xcs_in_if.sv -----
// ----------------------------------------------------------------------------
// xcs_in_if
// Input item channel: kind and value with valid/ready.
// ----------------------------------------------------------------------------
interface xcs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

// ----- rtl/xcs_out_if.sv -----
// ----------------------------------------------------------------------------
// xcs_out_if
// Result channel: one byte or event per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface xcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic [2:0] event_res;
  logic       is_send;
  logic       last;

  modport source (output valid, tx_byte, event_res, is_send, last, input ready);
  modport sink   (input valid, tx_byte, event_res, is_send, last, output ready);
endinterface

// ----- rtl/xcs_front.sv -----
// ----------------------------------------------------------------------------
// xcs_front
// Session state machine: while the queue has room, takes one item per
// cycle, updates the framing state and queues the bytes/events it yields.
// ----------------------------------------------------------------------------
module xcs_front #(
  parameter int BLOCK_BYTES = xcs_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  xcs_pkg::cfg_t  cfg,
  xcs_in_if.sink         item_in,
  output logic           push,
  output xcs_pkg::pkt_t  push_pkt,
  input  logic           push_ready
);

  localparam int PW = $clog2(BLOCK_BYTES + 1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_ANSWER = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [7:0]    block_seq, block_seq_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [3:0]    retries_left, retries_left_next;
  logic          eof_seen, eof_seen_next;
  xcs_pkg::pkt_t pkt;
  logic          accept;
  logic [PW-1:0] pos_inc;
  logic          full;
  logic [7:0]    sum_add;

  assign item_in.ready = push_ready;
  assign accept        = item_in.valid && push_ready;
  assign pos_inc       = byte_pos + PW'(1);
  assign full          = pos_inc >= PW'(BLOCK_BYTES);
  assign sum_add       = running_sum + item_in.value;

  always_comb begin
    phase_next        = phase;
    block_seq_next    = block_seq;
    byte_pos_next     = byte_pos;
    running_sum_next  = running_sum;
    retries_left_next = retries_left;
    eof_seen_next     = eof_seen;
    pkt               = '0;
    pkt.count         = 3'd1;
    pkt.ent[0]        = xcs_pkg::mk_res(8'h00, xcs_pkg::EV_REJECT, 1'b0);
    case (phase)
      PH_IDLE: begin
        if (item_in.kind == xcs_pkg::KIND_START) begin
          block_seq_next    = 8'd1;
          byte_pos_next     = '0;
          running_sum_next  = '0;
          retries_left_next = cfg.answer_retries;
          eof_seen_next     = 1'b0;
          phase_next        = PH_START;
          pkt.ent[0]        = xcs_pkg::mk_send(cfg.start_char);
        end
      end
      PH_START: begin
        if (item_in.kind == xcs_pkg::KIND_TICK) begin
          pkt.ent[0] = xcs_pkg::mk_send(cfg.start_char);
        end else if (item_in.kind == xcs_pkg::KIND_ANSWER) begin
          if (item_in.value == xcs_pkg::CH_NAK) begin
            phase_next = PH_DATA;
            pkt.count  = 3'd0;
          end else begin
            phase_next = PH_IDLE;
            pkt.ent[0] = xcs_pkg::mk_res(8'h00, xcs_pkg::EV_START_FAIL, 1'b0);
          end
        end
      end
      PH_DATA: begin
        if (item_in.kind == xcs_pkg::KIND_DATA) begin
          running_sum_next = sum_add;
          byte_pos_next    = pos_inc;
          if (byte_pos == '0) begin
            pkt.count  = 3'd4;
            pkt.ent[0] = xcs_pkg::mk_send(xcs_pkg::CH_SOH);
            pkt.ent[1] = xcs_pkg::mk_send(block_seq);
            pkt.ent[2] = xcs_pkg::mk_send(~block_seq);
            pkt.ent[3] = xcs_pkg::mk_send(item_in.value);
          end else begin
            pkt.ent[0] = xcs_pkg::mk_send(item_in.value);
            if (full) begin
              pkt.count         = 3'd2;
              pkt.ent[1]        = xcs_pkg::mk_send(sum_add);
              phase_next        = PH_ANSWER;
              retries_left_next = cfg.answer_retries;
            end
          end
        end else if (item_in.kind == xcs_pkg::KIND_TICK) begin
          pkt.count = 3'd0;
        end else if (item_in.kind == xcs_pkg::KIND_EOF) begin
          eof_seen_next = 1'b1;
          if (byte_pos == '0) begin
            pkt.ent[0] = xcs_pkg::mk_res(xcs_pkg::CH_EOT, xcs_pkg::EV_DONE, 1'b1);
            phase_next = PH_IDLE;
          end else begin
            pkt.count  = 3'd0;
            phase_next = PH_PAD;
          end
        end
      end
      PH_PAD: begin
        if (item_in.kind == xcs_pkg::KIND_TICK) begin
          byte_pos_next = pos_inc;
          pkt.ent[0]    = xcs_pkg::mk_send(8'h00);
          if (full) begin
            pkt.count         = 3'd2;
            pkt.ent[1]        = xcs_pkg::mk_send(running_sum);
            phase_next        = PH_ANSWER;
            retries_left_next = cfg.answer_retries;
          end
        end
      end
      PH_ANSWER: begin
        if (item_in.kind == xcs_pkg::KIND_ANSWER &&
            item_in.value == xcs_pkg::CH_ACK) begin
          block_seq_next    = block_seq + 8'd1;
          byte_pos_next     = '0;
          running_sum_next  = '0;
          retries_left_next = cfg.answer_retries;
          if (eof_seen) begin
            pkt.ent[0] = xcs_pkg::mk_res(xcs_pkg::CH_EOT, xcs_pkg::EV_DONE, 1'b1);
            phase_next = PH_IDLE;
          end else begin
            pkt.count  = 3'd0;
            phase_next = PH_DATA;
          end
        end else if (item_in.kind == xcs_pkg::KIND_ANSWER &&
                     item_in.value == xcs_pkg::CH_NAK) begin
          pkt.count  = 3'd3;
          pkt.ent[0] = xcs_pkg::mk_send(xcs_pkg::CH_EOT);
          pkt.ent[1] = xcs_pkg::mk_send(xcs_pkg::CH_CAN);
          pkt.ent[2] = xcs_pkg::mk_res(xcs_pkg::CH_CAN, xcs_pkg::EV_NAK_ABORT, 1'b1);
          phase_next = PH_IDLE;
        end else if (item_in.kind == xcs_pkg::KIND_ANSWER ||
                     item_in.kind == xcs_pkg::KIND_TICK) begin
          if (retries_left != '0) begin
            retries_left_next = retries_left - 4'd1;
            pkt.count         = 3'd0;
          end else begin
            pkt.count  = 3'd4;
            pkt.ent[0] = xcs_pkg::mk_send(xcs_pkg::CH_EOT);
            pkt.ent[1] = xcs_pkg::mk_send(xcs_pkg::CH_EOT);
            pkt.ent[2] = xcs_pkg::mk_send(xcs_pkg::CH_EOT);
            pkt.ent[3] = xcs_pkg::mk_res(xcs_pkg::CH_EOT, xcs_pkg::EV_RETRY_ABORT,
                                         1'b1);
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign push     = accept && (pkt.count != 3'd0);
  assign push_pkt = pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      block_seq    <= 8'd1;
      byte_pos     <= '0;
      running_sum  <= '0;
      retries_left <= xcs_pkg::RETRIES_RST;
      eof_seen     <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      block_seq    <= block_seq_next;
      byte_pos     <= byte_pos_next;
      running_sum  <= running_sum_next;
      retries_left <= retries_left_next;
      eof_seen     <= eof_seen_next;
    end
  end

endmodule

// ----- rtl/xcs_queue.sv -----
// ----------------------------------------------------------------------------
// xcs_queue
// Short queue of result groups between the front and back ends.
// ----------------------------------------------------------------------------
module xcs_queue #(
  parameter int DEPTH = xcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  xcs_pkg::pkt_t wr_pkt,
  output logic          wr_ready,
  output logic          rd_valid,
  output xcs_pkg::pkt_t rd_pkt,
  input  logic          rd_en
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xcs_pkg::pkt_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr, do_rd;

  assign wr_ready = fill != CW'(DEPTH);
  assign rd_valid = fill != '0;
  assign rd_pkt   = mem[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/xcs_back.sv -----
// ----------------------------------------------------------------------------
// xcs_back
// Unpacks each queued group into single results behind an output register.
// ----------------------------------------------------------------------------
module xcs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_valid,
  input  xcs_pkg::pkt_t rd_pkt,
  output logic          rd_en,
  xcs_out_if.source     result_out
);

  logic [1:0]    idx;
  logic          load;
  logic          is_last;
  logic          out_valid;
  xcs_pkg::res_t out_res;
  logic          out_last;

  assign load    = rd_valid && (!out_valid || result_out.ready);
  assign is_last = {1'b0, idx} == (rd_pkt.count - 3'd1);
  assign rd_en   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= rd_pkt.ent[idx];
      out_last <= is_last;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.tx_byte   = out_res.tx_byte;
  assign result_out.event_res = out_res.event_res;
  assign result_out.is_send   = out_res.is_send;
  assign result_out.last      = out_last;

endmodule

// ----- rtl/xmodem_checksum_sender.sv -----
// ----------------------------------------------------------------------------
// xmodem_checksum_sender
// XMODEM checksum-variant transmit framer.
// ----------------------------------------------------------------------------
// One item is taken per cycle while the result queue has room; each item
// yields zero to four results (up to four for a block opening or an
// abort), delivered one per cycle while the receiver is ready, so the
// sustained rate is set by the output port. The session state machine
// updates in the cycle an item is accepted; a queue of QUEUE_DEPTH result
// groups and an output register decouple it from a stalled receiver.
module xmodem_checksum_sender #(
  parameter int BLOCK_BYTES = xcs_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = xcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  xcs_in_if.sink     item_in,
  xcs_out_if.source  result_out
);

  xcs_pkg::cfg_t cfg;
  logic          push, push_ready;
  xcs_pkg::pkt_t push_pkt, rd_pkt;
  logic          rd_valid, rd_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.answer_retries <= xcs_pkg::RETRIES_RST;
      cfg.start_char     <= xcs_pkg::START_CHAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        xcs_pkg::CFG_RETRIES:    cfg.answer_retries <= cfg_data[3:0];
        xcs_pkg::CFG_START_CHAR: cfg.start_char     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  xcs_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_in    (item_in),
    .push       (push),
    .push_pkt   (push_pkt),
    .push_ready (push_ready)
  );

  xcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_pkt   (push_pkt),
    .wr_ready (push_ready),
    .rd_valid (rd_valid),
    .rd_pkt   (rd_pkt),
    .rd_en    (rd_en)
  );

  xcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_valid   (rd_valid),
    .rd_pkt     (rd_pkt),
    .rd_en      (rd_en),
    .result_out (result_out)
  );

  a_event_is_last: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.event_res != xcs_pkg::EV_SEND |-> result_out.last)
    else $error("outcome event not marked last");

  a_nosend_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.is_send |-> result_out.tx_byte == 8'h00)
    else $error("non-send result carries a byte");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("result group pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_valid && rd_pkt.count != 3'd0)
    else $error("pop from empty queue");

endmodule
